// ===== src/dq_pkg.sv =====
// dq_pkg: shared types, constants and pointer helpers for the double-ended queue
// no dependencies; imported by dq_ctrl, dq_datapath and double_ended_queue_unit
package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_RESP = 2'd2
    } t_fsm;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the request beat
        logic step;     // apply the request to the ring
    } t_dq_cmd;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == '0) begin
            r = IDX_W'(DEPTH - 1);
        end else begin
            r = i - 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/dq_ctrl.sv =====
// dq_ctrl: sequencing state machine for the double-ended queue
// depends on dq_pkg (t_fsm, t_dq_cmd)
module dq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dq_pkg::t_dq_cmd o_cmd
);
    import dq_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            FSM_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                o_cmd.step = 1'b1;
                n_state    = FSM_RESP;
            end
            FSM_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dq_datapath.sv =====
// dq_datapath: ring storage, head/tail pointers, occupancy and result registers
// depends on dq_pkg (types, DEPTH, pointer helpers)
module dq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dq_pkg::t_dq_cmd               i_cmd,
    input  logic [1:0]                    i_action,
    input  logic signed [dq_pkg::WORD_W-1:0] i_push_value,
    output logic signed [dq_pkg::WORD_W-1:0] o_popped_value,
    output logic [1:0]                    o_status,
    output logic [dq_pkg::COUNT_W-1:0]    o_fill_count
);
    import dq_pkg::*;

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rdata;

    t_action            r_action;
    logic [WORD_W-1:0]  r_value;

    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [COUNT_W-1:0] r_count;
    t_status            r_status;
    logic               r_pop_ok;

    logic [IDX_W-1:0]   n_head;
    logic [IDX_W-1:0]   n_tail;
    logic [COUNT_W-1:0] n_count;
    t_status            n_status;
    logic               n_pop_ok;
    logic [IDX_W-1:0]   mem_addr;
    logic               mem_we;
    logic               mem_re;
    logic               is_full;
    logic               is_empty;

    assign is_full  = (r_count == COUNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = STS_OK;
        n_pop_ok = 1'b0;
        mem_addr = r_head;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        case (r_action)
            ACT_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = STS_FULL;
                end else begin
                    mem_addr = idx_prev(r_head);
                    mem_we   = 1'b1;
                    n_head   = mem_addr;
                    n_count  = r_count + 1'b1;
                end
            end
            ACT_PUSH_REAR: begin
                if (is_full) begin
                    n_status = STS_FULL;
                end else begin
                    mem_addr = r_tail;
                    mem_we   = 1'b1;
                    n_tail   = idx_next(r_tail);
                    n_count  = r_count + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (is_empty) begin
                    n_status = STS_EMPTY;
                end else begin
                    mem_addr = r_head;
                    mem_re   = 1'b1;
                    n_pop_ok = 1'b1;
                    n_head   = idx_next(r_head);
                    n_count  = r_count - 1'b1;
                end
            end
            ACT_POP_REAR: begin
                if (is_empty) begin
                    n_status = STS_EMPTY;
                end else begin
                    mem_addr = idx_prev(r_tail);
                    mem_re   = 1'b1;
                    n_pop_ok = 1'b1;
                    n_tail   = mem_addr;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
    end

    // request capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_value  <= i_push_value;
        end
    end

    // ring storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && mem_we) begin
            r_mem[mem_addr] <= r_value;
        end
        if (i_cmd.step && mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_status <= STS_OK;
            r_pop_ok <= 1'b0;
        end else if (i_cmd.step) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    assign o_popped_value = r_pop_ok ? r_rdata : '0;
    assign o_status       = r_status;
    assign o_fill_count   = r_count;

endmodule

// ===== src/double_ended_queue_unit.sv =====
// double_ended_queue_unit: top level of the bounded double-ended queue
// depends on dq_pkg, dq_ctrl and dq_datapath
// usage
//   request channel: i_in_valid / o_in_ready carry one beat of i_action and
//   i_push_value (0 push front, 1 push rear, 2 pop front, 3 pop rear)
//   response channel: o_out_valid / i_out_ready carry one beat per request:
//   o_popped_value (zero unless a pop succeeded), o_status (0 ok, 1 empty,
//   2 full) and o_fill_count, the stored word count after the request
//   a refused push or pop leaves the ring untouched
// timing
//   request accepted in idle, ring updated in the next cycle (single-port
//   storage access plus pointer update), response valid the cycle after
//   that; one request in flight, so a new request is taken only after the
//   response beat is taken, through the idle/execute/respond sequence
// reset
//   synchronous active-low reset empties the queue (pointers and count to
//   zero); ring contents are not cleared and are never read before written
// back-pressure
//   while i_out_ready is low the response holds steady and o_in_ready stays
//   low; nothing is dropped
module double_ended_queue_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_action,
    input  logic signed [dq_pkg::WORD_W-1:0] i_push_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [dq_pkg::WORD_W-1:0] o_popped_value,
    output logic [1:0]                       o_status,
    output logic [dq_pkg::COUNT_W-1:0]       o_fill_count
);
    import dq_pkg::*;

    // command bundle from sequencer to datapath
    t_dq_cmd cmd;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

endmodule

// ===== tb/dq_reply_checker.sv =====
// dq_reply_checker: watches both channels of double_ended_queue_unit, tracks the ring
// on its own and compares every reply beat with the oldest predicted reply
// depends on dq_pkg only
module dq_reply_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [1:0]                       i_action,
    input  logic signed [dq_pkg::WORD_W-1:0] i_push_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [dq_pkg::WORD_W-1:0] i_popped_value,
    input  logic [1:0]                       i_status,
    input  logic [dq_pkg::COUNT_W-1:0]       i_fill_count,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        t_status                  sts;
        logic [COUNT_W-1:0]       fill;
    } t_deque_reply;

    logic signed [WORD_W-1:0] ring_words [DEPTH];
    int                       front_slot;
    int                       back_slot;   // next free slot behind the rear word
    int                       stored;
    t_deque_reply             awaited_replies [$];

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // applies one request to the tracked ring and returns the reply it must produce
    function automatic t_deque_reply apply_request(input t_action act,
                                                   input logic signed [WORD_W-1:0] word);
        t_deque_reply r;
        r.word = '0;
        r.sts  = STS_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (stored == DEPTH) begin
                    r.sts = STS_FULL;
                end else if (act == ACT_PUSH_FRONT) begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    ring_words[front_slot] = word;
                    stored++;
                end else begin
                    ring_words[back_slot] = word;
                    back_slot = (back_slot + 1) % DEPTH;
                    stored++;
                end
            end
            default: begin
                if (stored == 0) begin
                    r.sts = STS_EMPTY;
                end else if (act == ACT_POP_FRONT) begin
                    r.word = ring_words[front_slot];
                    front_slot = (front_slot + 1) % DEPTH;
                    stored--;
                end else begin
                    back_slot = (back_slot + DEPTH - 1) % DEPTH;
                    r.word = ring_words[back_slot];
                    stored--;
                end
            end
        endcase
        r.fill = COUNT_W'(stored);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_deque_reply due;
        if (!i_rst_n) begin
            foreach (ring_words[k]) ring_words[k] = '0;
            front_slot = 0;
            back_slot  = 0;
            stored     = 0;
            awaited_replies.delete();
        end else begin
            // reply first, so a beat never meets a prediction made at the same edge
            if (i_out_valid && i_out_ready) begin
                if (awaited_replies.size() == 0) begin
                    note_mismatch($sformatf("reply beat with nothing expected (word %0d)",
                                            i_popped_value));
                end else begin
                    due = awaited_replies.pop_front();
                    if (i_popped_value !== due.word)
                        note_mismatch($sformatf("popped value %0d, expected %0d",
                                                i_popped_value, due.word));
                    if (i_status !== due.sts)
                        note_mismatch($sformatf("status %0d, expected %s",
                                                i_status, due.sts.name()));
                    if (i_fill_count !== due.fill)
                        note_mismatch($sformatf("fill count %0d, expected %0d",
                                                i_fill_count, due.fill));
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_replies.push_back(apply_request(t_action'(i_action), i_push_value));
        end
        o_pending = awaited_replies.size();
    end

endmodule

// ===== tb/tb_double_ended_queue_unit.sv =====
// tb_double_ended_queue_unit: stimulus and verdict for double_ended_queue_unit
// depends on dq_pkg, the block's rtl and dq_reply_checker
module tb_double_ended_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    // how a random burst leans between pushes and pops
    typedef enum int {
        FILL_LEAN,
        DRAIN_LEAN,
        EVEN_MIX
    } t_lean;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_PCT     = 14;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_ready;
    logic [1:0]               req_action;
    logic signed [WORD_W-1:0] req_word;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic signed [WORD_W-1:0] rsp_word;
    logic [1:0]               rsp_status;
    logic [COUNT_W-1:0]       rsp_fill;
    logic                     calm;       // high while neither side may idle
    int                       fail_count;
    int                       pending;

    double_ended_queue_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_action       (req_action),
        .i_push_value   (req_word),
        .o_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .o_popped_value (rsp_word),
        .o_status       (rsp_status),
        .o_fill_count   (rsp_fill)
    );

    dq_reply_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .i_in_ready     (req_ready),
        .i_action       (req_action),
        .i_push_value   (req_word),
        .i_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .i_popped_value (rsp_word),
        .i_status       (rsp_status),
        .i_fill_count   (rsp_fill),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 12 ns period, low phase first so no edge lands at time zero
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // reply side stalls at random outside the calm stretch
    always @(posedge clk) begin
        rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // one request beat: optional idle cycles with valid low, then hold until accepted
    // valid is only lowered when a gap is taken, so back-to-back beats keep it high
    task automatic send_request(input t_action act, input logic signed [WORD_W-1:0] word);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_action <= act;
        req_word   <= word;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    initial begin : stimulus
        int                       k;
        int                       j;
        int                       sent;
        int                       burst;
        int                       push_pct;
        t_lean                    lean;
        t_action                  act;
        logic signed [WORD_W-1:0] word;

        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_action <= ACT_PUSH_FRONT;
        req_word   <= '0;
        rsp_ready  <= 1'b0;
        calm       <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pops on an empty queue, the second one carrying a nonzero word to ignore
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_REAR, '1);
        // only word pushed at one end and popped from the other
        send_request(ACT_PUSH_FRONT, 32'sh7fff_ffff);
        send_request(ACT_POP_REAR, '0);
        send_request(ACT_PUSH_REAR, 32'sh8000_0000);
        send_request(ACT_POP_FRONT, '1);
        // fill to the brim from both ends, wrapping the head pointer
        for (k = 0; k < DEPTH; k++) begin
            act = (k % 2 == 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
            case (k)
                0:       word = '0;
                1:       word = '1;
                2:       word = 32'sh7fff_ffff;
                3:       word = 32'sh8000_0000;
                default: word = (k % 2 == 1) ? (32'sh5555_5555 ^ k) : (32'shaaaa_aaaa ^ k);
            endcase
            send_request(act, word);
        end
        // refused pushes on a full queue, then pops from both ends
        send_request(ACT_PUSH_FRONT, 32'sh1234_5678);
        send_request(ACT_PUSH_REAR, 32'sh8765_4321);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_REAR, '0);

        // random bursts leaning toward filling, draining or neither,
        // so the full and empty edges are crossed again and again
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            lean  = t_lean'($urandom_range(2));
            burst = $urandom_range(40, 10);
            calm <= (sent >= 300 && sent < 450);
            case (lean)
                FILL_LEAN:  push_pct = 80;
                DRAIN_LEAN: push_pct = 20;
                default:    push_pct = 50;
            endcase
            for (j = 0; j < burst; j++) begin
                if ($urandom_range(99) < push_pct)
                    act = $urandom_range(1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
                else
                    act = $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
                case ($urandom_range(9))
                    0:       word = 32'sh8000_0000;
                    1:       word = 32'sh7fff_ffff;
                    2:       word = '0;
                    default: word = $urandom;
                endcase
                send_request(act, word);
            end
            sent += burst;
        end
        req_valid <= 1'b0;
        calm      <= 1'b0;

        // drain: sample on the falling edge, after the checker has seen the rising one
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("double_ended_queue_unit regression: pass");
        end else begin
            $display("double_ended_queue_unit regression: fail");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("double_ended_queue_unit regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue_unit.sv
tb/dq_reply_checker.sv
tb/tb_double_ended_queue_unit.sv
